@@ hdl/rhc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared widths, codes and pipeline payload types for the RGB to HSL converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int FRAC_BITS = 12;
  localparam int CH_W      = 8;
  localparam int SUM_W     = CH_W + 1;
  localparam int HUE_W     = 12;
  localparam int SAT_W     = 13;

  // One quotient bit per divider step; the extra top bit covers a full saturation.
  localparam int Q_W       = FRAC_BITS + 1;

  // The hue divisor is 6*diff, which needs three bits more than a channel.
  localparam int HDIV_W    = CH_W + 3;
  localparam int HREM_W    = HDIV_W + 1;
  localparam int SDIV_W    = CH_W;
  localparam int SREM_W    = SDIV_W + 1;

  typedef enum logic [1:0] {
    REG_RED,
    REG_GREEN,
    REG_BLUE
  } rhc_region_t;

  // Payload carried through the divider stages.
  typedef struct packed {
    logic [HREM_W-1:0] hrem;
    logic [HDIV_W-1:0] hdiv;
    logic [SREM_W-1:0] srem;
    logic [SDIV_W-1:0] sdiv;
    logic [Q_W-1:0]    hq;
    logic [Q_W-1:0]    sq;
    logic [SUM_W-1:0]  lsum;
    logic              achrom;
  } rhc_div_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [SUM_W-1:0] lsum;
    logic             achrom;
  } rhc_res_t;

endpackage

@@ hdl/rhc_div_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_div_pipe
// Pipelined restoring divider that produces one hue and one saturation
// quotient bit per stage, most significant bit first.
// ----------------------------------------------------------------------------
module rhc_div_pipe (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             div_in_v,
  input  rhc_pkg::rhc_div_t div_in,
  output logic             div_out_v,
  output rhc_pkg::rhc_div_t div_out
);
  import rhc_pkg::*;

  logic     v_r     [Q_W];
  rhc_div_t stage_r [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic     vin;
    rhc_div_t src;
    rhc_div_t nxt;

    if (i == 0) begin : g_first
      assign vin = div_in_v;
      assign src = div_in;
    end else begin : g_next
      assign vin = v_r[i-1];
      assign src = stage_r[i-1];
    end

    always_comb begin
      logic              hbit;
      logic              sbit;
      logic [HREM_W-1:0] hsub;
      logic [SREM_W-1:0] ssub;
      hbit = (src.hrem >= {1'b0, src.hdiv});
      hsub = hbit ? (src.hrem - {1'b0, src.hdiv}) : src.hrem;
      sbit = (src.srem >= {1'b0, src.sdiv});
      ssub = sbit ? (src.srem - {1'b0, src.sdiv}) : src.srem;
      nxt        = src;
      // The remainder is below the divisor here, so the shift cannot overflow.
      nxt.hrem   = {hsub[HREM_W-2:0], 1'b0};
      nxt.srem   = {ssub[SREM_W-2:0], 1'b0};
      nxt.hq     = {src.hq[Q_W-2:0], hbit};
      nxt.sq     = {src.sq[Q_W-2:0], sbit};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage_r[i] <= nxt;
      end
    end
  end

  assign div_out_v = v_r[Q_W-1];
  assign div_out   = stage_r[Q_W-1];

endmodule

@@ hdl/rgb_to_hsl_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// Converts one 8-bit RGB pixel per item to fixed-point hue, saturation and
// the max+min lightness sum.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_stall  | in_red, in_green, in_blue
//  result   | out_valid / out_stall| out_hue, out_saturation, out_lightness_sum,
//           |                      | out_achromatic
//
// One item enters per clock while in_stall is low; it passes stage 1, stage 2,
// the divider, which resolves one quotient bit per stage, and the output register.
// Reset (rst_n low, synchronous) clears all valid bits; no clearing pass.
// A stalled result parks one item in a skid register; the pipeline freezes
// only while that register is full, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [rhc_pkg::CH_W-1:0]  in_red,
  input  logic [rhc_pkg::CH_W-1:0]  in_green,
  input  logic [rhc_pkg::CH_W-1:0]  in_blue,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [rhc_pkg::HUE_W-1:0] out_hue,
  output logic [rhc_pkg::SAT_W-1:0] out_saturation,
  output logic [rhc_pkg::SUM_W-1:0] out_lightness_sum,
  output logic                      out_achromatic
);
  import rhc_pkg::*;

  logic en;

  // Stage 1: extremes, spread and sum.
  logic               s1_v_r;
  logic [CH_W-1:0]    s1_diff_r;
  logic [SUM_W-1:0]   s1_sum_r;
  rhc_region_t        s1_reg_r;
  logic signed [CH_W:0] s1_delta_r;

  logic [CH_W-1:0]    mx;
  logic [CH_W-1:0]    mn;
  rhc_region_t        s1_reg_nxt;
  logic signed [CH_W:0] s1_delta_nxt;

  // Stage 2: divider operands.
  logic               s2_v_r;
  rhc_div_t           s2_r;
  rhc_div_t           s2_nxt;

  logic               lst_v;
  rhc_div_t           lst;
  rhc_res_t           lst_res;

  logic               out_valid_r;
  rhc_res_t           out_r;
  logic               out_valid_nxt;
  rhc_res_t           out_nxt;
  logic               skid_valid_r;
  rhc_res_t           skid_r;
  logic               skid_valid_nxt;
  logic               out_ld;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  always_comb begin
    mx = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx) mx = in_blue;
    mn = in_red;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn) mn = in_blue;

    // Ties go to red first, then green.
    if (in_red >= in_green && in_red >= in_blue) begin
      s1_reg_nxt   = REG_RED;
      s1_delta_nxt = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
    end else if (in_green >= in_blue) begin
      s1_reg_nxt   = REG_GREEN;
      s1_delta_nxt = $signed({1'b0, in_blue}) - $signed({1'b0, in_red});
    end else begin
      s1_reg_nxt   = REG_BLUE;
      s1_delta_nxt = $signed({1'b0, in_red}) - $signed({1'b0, in_green});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_diff_r  <= mx - mn;
      s1_sum_r   <= {1'b0, mx} + {1'b0, mn};
      s1_reg_r   <= s1_reg_nxt;
      s1_delta_r <= s1_delta_nxt;
      s2_r       <= s2_nxt;
    end
  end

  always_comb begin
    logic [HDIV_W-1:0] d1;
    logic [HDIV_W-1:0] d6;
    logic [HDIV_W-1:0] hoff;
    logic [SUM_W-1:0]  den;
    d1  = HDIV_W'(s1_diff_r);
    d6  = (d1 << 2) + (d1 << 1);
    den = (s1_sum_r > SUM_W'(255)) ? (SUM_W'(510) - s1_sum_r) : s1_sum_r;
    case (s1_reg_r)
      REG_RED:   hoff = s1_delta_r[CH_W] ? d6 : '0;
      REG_GREEN: hoff = d1 << 1;
      REG_BLUE:  hoff = d1 << 2;
      default:   hoff = '0;
    endcase
    s2_nxt        = '0;
    // Hue numerator lands in 0 .. 6*diff-1, so the sum wraps into range.
    s2_nxt.hrem   = {1'b0, hoff + {{(HDIV_W-CH_W-1){s1_delta_r[CH_W]}}, s1_delta_r}};
    s2_nxt.hdiv   = d6;
    s2_nxt.srem   = {1'b0, s1_diff_r};
    s2_nxt.sdiv   = den[SDIV_W-1:0];
    s2_nxt.lsum   = s1_sum_r;
    s2_nxt.achrom = (s1_diff_r == '0);
  end

  rhc_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .div_in_v  (s2_v_r),
    .div_in    (s2_r),
    .div_out_v (lst_v),
    .div_out   (lst)
  );

  // A gray pixel has a zero hue divisor, so its quotients are forced to zero.
  always_comb begin
    lst_res.hue    = lst.achrom ? '0 : HUE_W'(lst.hq);
    lst_res.sat    = lst.achrom ? '0 : SAT_W'(lst.sq);
    lst_res.lsum   = lst.lsum;
    lst_res.achrom = lst.achrom;
  end

  assign out_ld = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_ld) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (lst_v) begin
      if (out_ld) begin
        out_valid_nxt = 1'b1;
        out_nxt       = lst_res;
      end else begin
        skid_valid_nxt = 1'b1;
      end
    end else if (out_ld) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!skid_valid_r) begin
      skid_r <= lst_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hue           = out_r.hue;
  assign out_saturation    = out_r.sat;
  assign out_lightness_sum = out_r.lsum;
  assign out_achromatic    = out_r.achrom;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled without a stalled result");

  a_gray_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.achrom) |-> (out_r.hue == '0 && out_r.sat == '0))
    else $error("gray pixel with nonzero hue or saturation");

  a_gray_even_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.achrom) |-> (out_r.lsum[0] == 1'b0))
    else $error("gray pixel with odd lightness sum");
`endif

endmodule
